@@ design/sha_pkg.sv @@
// package for the streaming sha-256 hasher: sizes, round constants, initial hash values
// used by sha_core and sha256_stream_hasher_top; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package sha_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int LEN_POS     = 56;
    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef logic [31:0] word_t;

    // control from the sequencer to the compression core
    typedef struct packed {
        logic push;     // shift a loaded message word into the schedule
        logic start;    // copy chaining words into the working variables
        logic round;    // run one round
        logic finish;   // fold working variables into the chaining words
        logic restart;  // back to the initial hash values
    } core_ctrl_t;

    localparam word_t INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t ror(input word_t x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

endpackage

`default_nettype wire

@@ design/sha_core.sv @@
// sha-256 compression core: 16-word schedule window, working variables, chaining words
// one round per cycle; uses sha_pkg
`timescale 1ns / 1ps
`default_nettype none

module sha_core
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sha_pkg::core_ctrl_t ctrl,
    input  wire sha_pkg::word_t      load_word,
    input  wire logic [5:0]          round_idx,
    output sha_pkg::word_t           chain [8]
);

    sha_pkg::word_t w_reg [16];
    sha_pkg::word_t s_reg [8];
    sha_pkg::word_t chain_reg [8];
    sha_pkg::word_t w_new;
    sha_pkg::word_t t1;
    sha_pkg::word_t t2;

    always_comb
    begin
        w_new = w_reg[0] + w_reg[9]
              + (sha_pkg::ror(w_reg[1], 7) ^ sha_pkg::ror(w_reg[1], 18) ^ (w_reg[1] >> 3))
              + (sha_pkg::ror(w_reg[14], 17) ^ sha_pkg::ror(w_reg[14], 19)
                 ^ (w_reg[14] >> 10));
        t1 = s_reg[7]
           + (sha_pkg::ror(s_reg[4], 6) ^ sha_pkg::ror(s_reg[4], 11)
              ^ sha_pkg::ror(s_reg[4], 25))
           + ((s_reg[4] & s_reg[5]) ^ (~s_reg[4] & s_reg[6]))
           + sha_pkg::ROUND_K[round_idx] + w_reg[0];
        t2 = (sha_pkg::ror(s_reg[0], 2) ^ sha_pkg::ror(s_reg[0], 13)
              ^ sha_pkg::ror(s_reg[0], 22))
           + ((s_reg[0] & s_reg[1]) ^ (s_reg[0] & s_reg[2]) ^ (s_reg[1] & s_reg[2]));
    end

    // schedule window: entry 0 is the word of the current round
    always_ff @(posedge clk)
    begin
        if (ctrl.push || ctrl.round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= ctrl.push ? load_word : w_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            for (int i = 0; i < 8; i++)
                s_reg[i] <= chain_reg[i];
        end
        else if (ctrl.round)
        begin
            s_reg[7] <= s_reg[6];
            s_reg[6] <= s_reg[5];
            s_reg[5] <= s_reg[4];
            s_reg[4] <= s_reg[3] + t1;
            s_reg[3] <= s_reg[2];
            s_reg[2] <= s_reg[1];
            s_reg[1] <= s_reg[0];
            s_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= sha_pkg::INIT_H[i];
        end
        else if (ctrl.restart)
        begin
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= sha_pkg::INIT_H[i];
        end
        else if (ctrl.finish)
        begin
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= chain_reg[i] + s_reg[i];
        end
    end

    assign chain = chain_reg;

`ifndef SYNTHESIS
    a_ctrl_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({ctrl.start, ctrl.round, ctrl.finish, ctrl.restart}) <= 1)
        else $error("core control overlap");
    a_no_push_round: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.push && ctrl.round))
        else $error("push during round");
    a_finish_after_round: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |-> $past(ctrl.round))
        else $error("finish without rounds");
`endif

endmodule

`default_nettype wire

@@ design/sha256_stream_hasher_top.sv @@
// streaming sha-256 hasher top: input sequencer, 64-byte block buffer memory, digest output
// uses sha_pkg and sha_core
`timescale 1ns / 1ps
`default_nettype none

// usage:
// the input channel (in_valid / in_stall) takes one item per message byte, data_byte with
// has_byte set; is_last ends the message, an item without a byte may end it too (empty
// message) and an item with neither flag is a no-op.
// bytes go into a 64-byte buffer memory at one per cycle while the block is idle. a full
// block is read back byte by byte, run through 64 rounds of one shared round unit and
// folded into the chaining words, with in_stall high throughout, so no new byte is taken
// until that block is done.
// on the last item the buffer is padded one byte per cycle up to the end of the block,
// compressed, and if the length does not fit a second block is padded and compressed.
// the digest then leaves on the output channel (out_valid / out_stall) as four 64-bit parts,
// part_index 0..3, last_part on the fourth; a stalled part holds and no new item is taken
// until the fourth part is taken, after which the block starts the next message.
// reset (rst_n low, asynchronous) returns to idle with the initial hash values, an empty
// buffer count and a zero bit count; the buffer memory itself is not cleared.

module sha256_stream_hasher_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        has_byte,
    input  wire logic        is_last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      digest_part,
    output logic [1:0]       part_index,
    output logic             last_part
);

    typedef enum logic [2:0] {S_IDLE, S_PAD, S_LOAD, S_ROUND, S_FIN, S_OUT} state_t;
    typedef enum logic [1:0] {K_DATA, K_PADX, K_LEN} kind_t;

    state_t       state_reg, state_next;
    kind_t        kind_reg, kind_next;
    logic [6:0]   fill_reg, fill_next;
    logic [63:0]  bits_reg, bits_next;
    logic         last_reg, last_next;
    logic [5:0]   pad_addr_reg, pad_addr_next;
    logic         mark_reg, mark_next;
    logic         len_reg, len_next;
    logic [6:0]   ld_cnt_reg, ld_cnt_next;
    logic         rd_valid_reg, rd_valid_next;
    logic [5:0]   rd_idx_reg, rd_idx_next;
    logic [23:0]  word_reg, word_next;
    logic [5:0]   rcnt_reg, rcnt_next;
    logic [1:0]   part_reg, part_next;

    logic [7:0]   mem [sha_pkg::BLOCK_BYTES];
    logic [7:0]   rdata_reg;
    logic         we;
    logic [5:0]   waddr;
    logic [7:0]   wdata;
    logic         re;

    sha_pkg::core_ctrl_t ctrl;
    sha_pkg::word_t      load_word;
    sha_pkg::word_t      chain [8];

    logic         in_acc;
    logic [6:0]   fill_eff;
    logic [5:0]   len_shift;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign in_acc    = in_valid && !in_stall;
    assign fill_eff  = has_byte ? fill_reg + 7'd1 : fill_reg;
    assign len_shift = {~pad_addr_reg[2:0], 3'b000};
    assign load_word = {word_reg, rdata_reg};

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        fill_next     = fill_reg;
        bits_next     = bits_reg;
        last_next     = last_reg;
        pad_addr_next = pad_addr_reg;
        mark_next     = mark_reg;
        len_next      = len_reg;
        ld_cnt_next   = ld_cnt_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = rd_idx_reg;
        word_next     = word_reg;
        rcnt_next     = rcnt_reg;
        part_next     = part_reg;
        ctrl          = '0;
        we            = 1'b0;
        waddr         = pad_addr_reg;
        wdata         = 8'h00;
        re            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (has_byte)
                    begin
                        we        = 1'b1;
                        waddr     = fill_reg[5:0];
                        wdata     = data_byte;
                        bits_next = bits_reg + 64'd8;
                        fill_next = fill_eff;
                    end
                    last_next = 1'b0;
                    if (has_byte && fill_reg == 7'(sha_pkg::BLOCK_BYTES - 1))
                    begin
                        // full block: compress first, padding follows if last
                        state_next  = S_LOAD;
                        kind_next   = K_DATA;
                        ld_cnt_next = '0;
                        fill_next   = '0;
                        last_next   = is_last;
                    end
                    else if (is_last)
                    begin
                        state_next    = S_PAD;
                        pad_addr_next = fill_eff[5:0];
                        mark_next     = 1'b1;
                        len_next      = (fill_eff < 7'(sha_pkg::LEN_POS));
                    end
                end
            end
            S_PAD:
            begin
                we        = 1'b1;
                mark_next = 1'b0;
                if (mark_reg)
                    wdata = sha_pkg::PAD_MARK;
                else if (len_reg && pad_addr_reg >= 6'(sha_pkg::LEN_POS))
                    wdata = 8'(bits_reg >> len_shift);
                if (pad_addr_reg == 6'(sha_pkg::BLOCK_BYTES - 1))
                begin
                    state_next  = S_LOAD;
                    kind_next   = len_reg ? K_LEN : K_PADX;
                    ld_cnt_next = '0;
                end
                else
                    pad_addr_next = pad_addr_reg + 6'd1;
            end
            S_LOAD:
            begin
                if (!ld_cnt_reg[6])
                begin
                    re            = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_idx_next   = ld_cnt_reg[5:0];
                    ld_cnt_next   = ld_cnt_reg + 7'd1;
                end
                if (rd_valid_reg)
                begin
                    word_next = {word_reg[15:0], rdata_reg};
                    if (rd_idx_reg[1:0] == 2'd3)
                        ctrl.push = 1'b1;
                    if (rd_idx_reg == 6'(sha_pkg::BLOCK_BYTES - 1))
                    begin
                        ctrl.start = 1'b1;
                        rcnt_next  = '0;
                        state_next = S_ROUND;
                    end
                end
            end
            S_ROUND:
            begin
                ctrl.round = 1'b1;
                rcnt_next  = rcnt_reg + 6'd1;
                if (rcnt_reg == 6'd63)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                ctrl.finish = 1'b1;
                unique case (kind_reg)
                    K_DATA:
                    begin
                        if (last_reg)
                        begin
                            state_next    = S_PAD;
                            pad_addr_next = '0;
                            mark_next     = 1'b1;
                            len_next      = 1'b1;
                            last_next     = 1'b0;
                        end
                        else
                            state_next = S_IDLE;
                    end
                    K_PADX:
                    begin
                        state_next    = S_PAD;
                        pad_addr_next = '0;
                        mark_next     = 1'b0;
                        len_next      = 1'b1;
                    end
                    default:
                    begin
                        state_next = S_OUT;
                        part_next  = '0;
                    end
                endcase
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    if (part_reg == 2'd3)
                    begin
                        ctrl.restart = 1'b1;
                        fill_next    = '0;
                        bits_next    = '0;
                        last_next    = 1'b0;
                        state_next   = S_IDLE;
                    end
                    else
                        part_next = part_reg + 2'd1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            kind_reg     <= K_DATA;
            fill_reg     <= '0;
            bits_reg     <= '0;
            last_reg     <= 1'b0;
            pad_addr_reg <= '0;
            mark_reg     <= 1'b0;
            len_reg      <= 1'b0;
            ld_cnt_reg   <= '0;
            rd_valid_reg <= 1'b0;
            rd_idx_reg   <= '0;
            rcnt_reg     <= '0;
            part_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            fill_reg     <= fill_next;
            bits_reg     <= bits_next;
            last_reg     <= last_next;
            pad_addr_reg <= pad_addr_next;
            mark_reg     <= mark_next;
            len_reg      <= len_next;
            ld_cnt_reg   <= ld_cnt_next;
            rd_valid_reg <= rd_valid_next;
            rd_idx_reg   <= rd_idx_next;
            rcnt_reg     <= rcnt_next;
            part_reg     <= part_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    // block buffer: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[ld_cnt_reg[5:0]];
    end

    sha_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .load_word (load_word),
        .round_idx (rcnt_reg),
        .chain     (chain)
    );

    assign digest_part = {chain[{part_reg, 1'b0}], chain[{part_reg, 1'b1}]};
    assign part_index  = part_reg;
    assign last_part   = (part_reg == 2'd3);

`ifndef SYNTHESIS
    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !fill_reg[6])
        else $error("fill count out of range while idle");
    a_full_block_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && has_byte && fill_reg == 7'(sha_pkg::BLOCK_BYTES - 1) |=> state_reg == S_LOAD)
        else $error("full block not compressed");
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_part |=> !out_valid && fill_reg == '0)
        else $error("message state not cleared after digest");
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken during digest output");
`endif

endmodule

`default_nettype wire

@@ tb/tb_sha256_stream_hasher_top.sv @@
// testbench for the streaming sha-256 hasher: directed table then random messages,
// each digest part checked against a sha-256 predictor in this file
// uses sha_pkg (initial hash values, round constants) and sha256_stream_hasher_top
`timescale 1ns / 1ps

module tb_sha256_stream_hasher_top;

    typedef struct {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
        logic       check_digest;   // typed-in first part applies
        logic [63:0] digest0;
    } stim_row_t;

    typedef struct {
        logic [63:0] digest_part;
        logic [1:0]  part_index;
        logic        last_part;
    } digest_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        has_byte = 1'b0;
    logic        is_last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b1;
    logic [63:0] digest_part;
    logic [1:0]  part_index;
    logic        last_part;

    // predictor state
    sha_pkg::word_t chain [8];
    logic [7:0]  msg_block [64];
    int unsigned fill;
    logic [63:0] bit_count;

    digest_item_t pending_parts [$];
    logic [63:0]  typed_first [$];
    logic         typed_valid [$];

    int  failures = 0;
    int  idle_pct_in = 0;
    int  stall_pct_out = 0;
    bit  hold_off = 1'b0;
    int  quiet_cycles = 0;
    localparam int WATCHDOG = 20000;

    sha256_stream_hasher_top uut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .has_byte(has_byte), .is_last(is_last),
        .out_valid(out_valid), .out_stall(out_stall),
        .digest_part(digest_part), .part_index(part_index), .last_part(last_part)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic sha_pkg::word_t rotr(sha_pkg::word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        sha_pkg::word_t w [64];
        sha_pkg::word_t s [8];
        sha_pkg::word_t t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        s = chain;
        for (int i = 0; i < 64; i++)
        begin
            t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
               + ((s[4] & s[5]) ^ (~s[4] & s[6])) + sha_pkg::ROUND_K[i] + w[i];
            t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
               + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
            s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
            s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] += s[i];
    endtask

    task automatic start_message();
        chain = sha_pkg::INIT_H;
        fill = 0;
        bit_count = '0;
    endtask

    // advance the hash by one accepted item, queue the four parts on a last item
    task automatic hash_item(logic [7:0] b, logic hb, logic lst);
        int unsigned p;
        if (hb)
        begin
            msg_block[fill] = b;
            fill++;
            bit_count += 64'd8;
            if (fill == sha_pkg::BLOCK_BYTES)
            begin
                compress_block();
                fill = 0;
            end
        end
        if (lst)
        begin
            p = fill;
            msg_block[p++] = sha_pkg::PAD_MARK;
            if (p > sha_pkg::LEN_POS)
            begin
                while (p < sha_pkg::BLOCK_BYTES) msg_block[p++] = 8'h00;
                compress_block();
                p = 0;
            end
            while (p < sha_pkg::LEN_POS) msg_block[p++] = 8'h00;
            for (int i = 0; i < 8; i++)
                msg_block[63-i] = bit_count[8*i +: 8];
            compress_block();
            for (int k = 0; k < 4; k++)
                pending_parts.push_back('{{chain[2*k], chain[2*k+1]}, 2'(k), k == 3});
            start_message();
        end
    endtask

    // valid stays high after an accepted item so the next one can follow at once
    task automatic send_item(logic [7:0] b, logic hb, logic lst, logic chk, logic [63:0] d0);
        while (idle_pct_in > 0 && $urandom_range(99, 0) < idle_pct_in)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        has_byte  <= hb;
        is_last   <= lst;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (lst)
        begin
            typed_first.push_back(d0);
            typed_valid.push_back(chk);
        end
        hash_item(b, hb, lst);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_parts.size() != 0) @(posedge clk);
    endtask

    // one message: random bytes, some no-op items, random split between last byte and finish-only item
    task automatic send_message(int unsigned len);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9, 0) == 0)
                send_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
            send_item(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(1, 0), 1'b0, '0);
        end
        if (fill != 0 || bit_count != 0 || len == 0)
            send_item(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
    endtask

    // output side: stall and check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_parts.size() == 0)
                begin
                    $error("digest part with none expected: %h", digest_part);
                    failures++;
                end
                else
                begin
                    digest_item_t e;
                    e = pending_parts.pop_front();
                    if (e.part_index == 2'd0 && typed_valid.size() != 0)
                    begin
                        if (typed_valid[0] && digest_part !== typed_first[0])
                        begin
                            $error("digest_part (known) expected %h got %h",
                                   typed_first[0], digest_part);
                            failures++;
                        end
                        void'(typed_valid.pop_front());
                        void'(typed_first.pop_front());
                    end
                    if (digest_part !== e.digest_part)
                    begin
                        $error("digest_part expected %h got %h", e.digest_part, digest_part);
                        failures++;
                    end
                    if (part_index !== e.part_index)
                    begin
                        $error("part_index expected %0d got %0d", e.part_index, part_index);
                        failures++;
                    end
                    if (last_part !== e.last_part)
                    begin
                        $error("last_part expected %0d got %0d", e.last_part, last_part);
                        failures++;
                    end
                end
            end
            out_stall <= hold_off || (stall_pct_out > 0 && $urandom_range(99, 0) < stall_pct_out);
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("FAIL");
            $finish;
        end
    end

    stim_row_t directed [$];

    initial
    begin
        start_message();
        for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
        // empty message, then "abc", then idle items and extremes
        directed.push_back('{8'h00, 1'b0, 1'b1, 1'b1, 64'he3b0c44298fc1c14});
        directed.push_back('{8'h00, 1'b0, 1'b0, 1'b0, '0});
        directed.push_back('{8'h61, 1'b1, 1'b0, 1'b0, '0});
        directed.push_back('{8'h62, 1'b1, 1'b0, 1'b0, '0});
        directed.push_back('{8'hff, 1'b0, 1'b0, 1'b0, '0});
        directed.push_back('{8'h63, 1'b1, 1'b1, 1'b1, 64'hba7816bf8f01cfea});
        directed.push_back('{8'hff, 1'b1, 1'b0, 1'b0, '0});
        directed.push_back('{8'h00, 1'b1, 1'b0, 1'b0, '0});
        directed.push_back('{8'h55, 1'b0, 1'b1, 1'b0, '0});
        directed.push_back('{8'haa, 1'b1, 1'b1, 1'b0, '0});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_item(directed[i].data_byte, directed[i].has_byte, directed[i].is_last,
                      directed[i].check_digest, directed[i].digest0);
        // full block, long padding and exact length-fit boundaries
        send_message(64);
        send_message(56);
        send_message(55);
        wait_drained();

        // random, in idling phases
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct_in   = (ph == 1 || ph == 3) ? 59 : 0;
            stall_pct_out = (ph == 2) ? 59 : 0;
            if (ph == 3)
            begin
                idle_pct_in = 13;
                stall_pct_out = 13;
            end
            for (int m = 0; m < 4; m++)
                send_message($urandom_range(6, 0));
        end
        idle_pct_in = 0;
        stall_pct_out = 0;

        // long receiver hold-off while messages keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                send_message(3);
                send_message(2);
                send_message(4);
            end
        join
        wait_drained();
        send_message(7);

        wait_drained();
        repeat (400) @(posedge clk);
        if (failures == 0 && pending_parts.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
